// File: rtl/derq_pkg.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// derq_pkg
// Shared types and codes for the double-ended ring queue.
// ----------------------------------------------------------------------------
package derq_pkg;

    localparam int DATA_W    = 32;
    localparam int KIND_W    = 2;
    localparam int STATUS_W  = 2;
    localparam int COUNT_W   = 4;
    localparam int DEPTH_DEF = 8;

    typedef logic signed [DATA_W-1:0] data_t;
    typedef logic [KIND_W-1:0]        kind_t;
    typedef logic [STATUS_W-1:0]      status_t;
    typedef logic [COUNT_W-1:0]       count_t;

    // operation codes
    localparam kind_t KIND_PUSH_BACK  = 2'd0;
    localparam kind_t KIND_PUSH_FRONT = 2'd1;
    localparam kind_t KIND_POP_FRONT  = 2'd2;
    localparam kind_t KIND_POP_BACK   = 2'd3;

    // result status codes
    localparam status_t STAT_DONE  = 2'd0;
    localparam status_t STAT_FULL  = 2'd1;
    localparam status_t STAT_EMPTY = 2'd2;

    // store port strobes
    typedef struct packed {
        logic we;
        logic re;
    } mem_ctl_t;

endpackage
`default_nettype wire

// File: rtl/double_ended_ring_queue_top.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// double_ended_ring_queue_top
// Double-ended queue over a circular element store of DEPTH entries.
// ----------------------------------------------------------------------------
// Each request carries an operation (push back, push front, pop front, pop
// back) and a data word, and yields exactly one result: status (done, full,
// empty), the popped word, the count after the operation, and the words now
// at the front and back (zero when empty). Refused requests leave the queue
// unchanged. The accept cycle updates pointers, count and the end-value
// registers and issues the store access; the resolve state then takes the
// new end element from the registered synchronous read of the store and loads
// the result register once that register is free. One request is in work
// at a time; a new one is taken as soon as the previous has been loaded
// into the result register, even if that result is still waiting for
// out_ready. The store needs no clearing after reset, since only live
// entries are ever read. Count is reported in 4 bits, so with DEPTH above
// 15 it is the held count modulo 16.
// ----------------------------------------------------------------------------
module double_ended_ring_queue_top #(
    parameter int DEPTH = derq_pkg::DEPTH_DEF
) (
    input  wire logic              clk,
    input  wire logic              rst_n,
    input  wire logic              in_valid,
    output logic                   in_ready,
    input  wire derq_pkg::kind_t   kind,
    input  wire derq_pkg::data_t   data,
    output logic                   out_valid,
    input  wire logic              out_ready,
    output derq_pkg::status_t      status,
    output derq_pkg::data_t        popped_value,
    output derq_pkg::count_t       count,
    output derq_pkg::data_t        front_value,
    output derq_pkg::data_t        back_value
);
    import derq_pkg::*;

    // store address width; DEPTH runs from 2 to 1024
    localparam int AW = $clog2(DEPTH);

    mem_ctl_t      mem_ctl;
    logic [AW-1:0] mem_waddr;
    logic [AW-1:0] mem_raddr;
    data_t         mem_wdata;
    data_t         mem_rdata;

    // pointers, count, end values and the result register
    derq_ctrl #(
        .DEPTH (DEPTH),
        .AW    (AW)
    ) u_ctrl (
        .clk          (clk),
        .rst_n        (rst_n),
        .in_valid     (in_valid),
        .in_ready     (in_ready),
        .kind         (kind),
        .data         (data),
        .out_valid    (out_valid),
        .out_ready    (out_ready),
        .status       (status),
        .popped_value (popped_value),
        .count        (count),
        .front_value  (front_value),
        .back_value   (back_value),
        .mem_ctl      (mem_ctl),
        .mem_waddr    (mem_waddr),
        .mem_wdata    (mem_wdata),
        .mem_raddr    (mem_raddr),
        .mem_rdata    (mem_rdata)
    );

    // element store: pushes write, pops read the new end element
    derq_mem #(
        .DEPTH (DEPTH),
        .AW    (AW)
    ) u_mem (
        .clk   (clk),
        .ctl   (mem_ctl),
        .waddr (mem_waddr),
        .wdata (mem_wdata),
        .raddr (mem_raddr),
        .rdata (mem_rdata)
    );

endmodule
`default_nettype wire

// File: rtl/derq_mem.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// derq_mem
// Element store: one write port, one read port, registered read data.
// ----------------------------------------------------------------------------
module derq_mem #(
    parameter int DEPTH = derq_pkg::DEPTH_DEF,
    parameter int AW    = $clog2(DEPTH)
) (
    input  wire logic              clk,
    input  wire derq_pkg::mem_ctl_t ctl,
    input  wire logic [AW-1:0]     waddr,
    input  wire derq_pkg::data_t   wdata,
    input  wire logic [AW-1:0]     raddr,
    output derq_pkg::data_t        rdata
);
    import derq_pkg::*;

    data_t slots_reg [DEPTH];
    data_t rdata_reg;

    always_ff @(posedge clk)
    begin
        if (ctl.we)
        begin
            slots_reg[waddr] <= wdata;
        end
        if (ctl.re)
        begin
            rdata_reg <= slots_reg[raddr];
        end
    end

    assign rdata = rdata_reg;

endmodule
`default_nettype wire

// File: rtl/derq_ctrl.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// derq_ctrl
// Pointer, count and end-value tracking, store access and result register.
// ----------------------------------------------------------------------------
module derq_ctrl #(
    parameter int DEPTH = derq_pkg::DEPTH_DEF,
    parameter int AW    = $clog2(DEPTH)
) (
    input  wire logic               clk,
    input  wire logic               rst_n,
    input  wire logic               in_valid,
    output logic                    in_ready,
    input  wire derq_pkg::kind_t    kind,
    input  wire derq_pkg::data_t    data,
    output logic                    out_valid,
    input  wire logic               out_ready,
    output derq_pkg::status_t       status,
    output derq_pkg::data_t         popped_value,
    output derq_pkg::count_t        count,
    output derq_pkg::data_t         front_value,
    output derq_pkg::data_t         back_value,
    output derq_pkg::mem_ctl_t      mem_ctl,
    output logic [AW-1:0]           mem_waddr,
    output derq_pkg::data_t         mem_wdata,
    output logic [AW-1:0]           mem_raddr,
    input  wire derq_pkg::data_t    mem_rdata
);
    import derq_pkg::*;

    localparam int CW = $clog2(DEPTH + 1);
    localparam logic [AW-1:0] LAST_IDX = AW'(DEPTH - 1);
    localparam logic [CW-1:0] FULL_CNT = CW'(DEPTH);
    localparam logic [CW-1:0] ONE_CNT  = CW'(1);

    localparam logic [0:0] ST_IDLE    = 1'b0;
    localparam logic [0:0] ST_RESOLVE = 1'b1;

    // which end value waits on the store read
    localparam logic [1:0] FIX_NONE  = 2'd0;
    localparam logic [1:0] FIX_FRONT = 2'd1;
    localparam logic [1:0] FIX_BACK  = 2'd2;

    function automatic logic [AW-1:0] idx_next(input logic [AW-1:0] i);
        return (i == LAST_IDX) ? '0 : i + AW'(1);
    endfunction

    function automatic logic [AW-1:0] idx_prev(input logic [AW-1:0] i);
        return (i == '0) ? LAST_IDX : i - AW'(1);
    endfunction

    logic [0:0]    state_reg, state_next;
    logic [AW-1:0] head_reg, head_next;
    logic [AW-1:0] tail_reg, tail_next;
    logic [CW-1:0] held_reg, held_next;
    data_t         front_reg, front_next;
    data_t         back_reg, back_next;
    logic          out_valid_reg, out_valid_next;

    status_t       pend_status_reg, pend_status_next;
    data_t         pend_popped_reg, pend_popped_next;
    logic [1:0]    pend_fix_reg, pend_fix_next;

    status_t       status_reg;
    data_t         popped_reg;
    count_t        count_reg;
    data_t         front_out_reg;
    data_t         back_out_reg;

    logic          accept;
    logic          load;
    logic          is_full;
    logic          is_empty;
    logic [AW-1:0] tail_prev;
    data_t         front_res;
    data_t         back_res;

    assign in_ready  = (state_reg == ST_IDLE);
    assign accept    = in_valid && in_ready;
    assign load      = (state_reg == ST_RESOLVE) && (!out_valid_reg || out_ready);
    assign is_full   = (held_reg == FULL_CNT);
    assign is_empty  = (held_reg == '0);
    assign tail_prev = idx_prev(tail_reg);

    assign front_res = (pend_fix_reg == FIX_FRONT) ? mem_rdata : front_reg;
    assign back_res  = (pend_fix_reg == FIX_BACK)  ? mem_rdata : back_reg;

    always_comb
    begin
        state_next       = state_reg;
        head_next        = head_reg;
        tail_next        = tail_reg;
        held_next        = held_reg;
        front_next       = front_reg;
        back_next        = back_reg;
        out_valid_next   = out_valid_reg;
        pend_status_next = pend_status_reg;
        pend_popped_next = pend_popped_reg;
        pend_fix_next    = pend_fix_reg;
        mem_ctl          = '0;
        mem_waddr        = tail_reg;
        mem_wdata        = data;
        mem_raddr        = head_reg;

        if (out_valid_reg && out_ready)
        begin
            out_valid_next = 1'b0;
        end

        if (accept)
        begin
            state_next       = ST_RESOLVE;
            pend_status_next = STAT_DONE;
            pend_popped_next = '0;
            pend_fix_next    = FIX_NONE;
            unique case (kind)
                KIND_PUSH_BACK:
                begin
                    if (is_full)
                    begin
                        pend_status_next = STAT_FULL;
                    end
                    else
                    begin
                        mem_ctl.we = 1'b1;
                        mem_waddr  = tail_reg;
                        tail_next  = idx_next(tail_reg);
                        held_next  = held_reg + ONE_CNT;
                        back_next  = data;
                        if (is_empty)
                        begin
                            front_next = data;
                        end
                    end
                end
                KIND_PUSH_FRONT:
                begin
                    if (is_full)
                    begin
                        pend_status_next = STAT_FULL;
                    end
                    else
                    begin
                        mem_ctl.we = 1'b1;
                        mem_waddr  = idx_prev(head_reg);
                        head_next  = idx_prev(head_reg);
                        held_next  = held_reg + ONE_CNT;
                        front_next = data;
                        if (is_empty)
                        begin
                            back_next = data;
                        end
                    end
                end
                KIND_POP_FRONT:
                begin
                    if (is_empty)
                    begin
                        pend_status_next = STAT_EMPTY;
                    end
                    else
                    begin
                        pend_popped_next = front_reg;
                        head_next        = idx_next(head_reg);
                        held_next        = held_reg - ONE_CNT;
                        if (held_reg == ONE_CNT)
                        begin
                            front_next = '0;
                            back_next  = '0;
                        end
                        else
                        begin
                            mem_ctl.re    = 1'b1;
                            mem_raddr     = idx_next(head_reg);
                            pend_fix_next = FIX_FRONT;
                        end
                    end
                end
                KIND_POP_BACK:
                begin
                    if (is_empty)
                    begin
                        pend_status_next = STAT_EMPTY;
                    end
                    else
                    begin
                        pend_popped_next = back_reg;
                        tail_next        = tail_prev;
                        held_next        = held_reg - ONE_CNT;
                        if (held_reg == ONE_CNT)
                        begin
                            front_next = '0;
                            back_next  = '0;
                        end
                        else
                        begin
                            mem_ctl.re    = 1'b1;
                            mem_raddr     = idx_prev(tail_prev);
                            pend_fix_next = FIX_BACK;
                        end
                    end
                end
                default:
                begin
                    pend_status_next = STAT_DONE;
                end
            endcase
        end

        if (load)
        begin
            state_next     = ST_IDLE;
            front_next     = front_res;
            back_next      = back_res;
            out_valid_next = 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            head_reg      <= '0;
            tail_reg      <= '0;
            held_reg      <= '0;
            front_reg     <= '0;
            back_reg      <= '0;
            out_valid_reg <= 1'b0;
            pend_fix_reg  <= FIX_NONE;
        end
        else
        begin
            state_reg     <= state_next;
            head_reg      <= head_next;
            tail_reg      <= tail_next;
            held_reg      <= held_next;
            front_reg     <= front_next;
            back_reg      <= back_next;
            out_valid_reg <= out_valid_next;
            pend_fix_reg  <= pend_fix_next;
        end
    end

    // payload registers
    always_ff @(posedge clk)
    begin
        pend_status_reg <= pend_status_next;
        pend_popped_reg <= pend_popped_next;
        if (load)
        begin
            status_reg    <= pend_status_reg;
            popped_reg    <= pend_popped_reg;
            count_reg     <= COUNT_W'(held_reg);
            front_out_reg <= front_res;
            back_out_reg  <= back_res;
        end
    end

    assign out_valid    = out_valid_reg;
    assign status       = status_reg;
    assign popped_value = popped_reg;
    assign count        = count_reg;
    assign front_value  = front_out_reg;
    assign back_value   = back_out_reg;

endmodule
`default_nettype wire

// File: rtl/derq_checker.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// derq_checker
// Port-level checks for the double-ended ring queue.
// ----------------------------------------------------------------------------
module derq_checker #(
    parameter int DEPTH = derq_pkg::DEPTH_DEF
) (
    input  wire logic              clk,
    input  wire logic              rst_n,
    input  wire logic              in_valid,
    input  wire logic              in_ready,
    input  wire logic              out_valid,
    input  wire logic              out_ready,
    input  wire derq_pkg::status_t status,
    input  wire derq_pkg::data_t   popped_value,
    input  wire derq_pkg::count_t  count,
    input  wire derq_pkg::data_t   front_value,
    input  wire derq_pkg::data_t   back_value
);
    import derq_pkg::*;

    localparam count_t FULL_COUNT = COUNT_W'(DEPTH);

    // stalled result holds
    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !out_ready |=> out_valid && $stable(status) && $stable(count)
            && $stable(popped_value))
        else $error("result changed while stalled");

    // empty queue shows zero ends
    a_empty_ends: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && count == '0 && (DEPTH % 16 != 0 || status != STAT_FULL)
            |-> front_value == '0 && back_value == '0)
        else $error("nonzero end value with empty queue");

    // refused pop reports empty queue and no value
    a_refused_pop: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && status == STAT_EMPTY |-> count == '0 && popped_value == '0)
        else $error("refused pop with elements held");

    // refused push reports a full queue
    a_refused_push: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && status == STAT_FULL |-> count == FULL_COUNT && popped_value == '0)
        else $error("refused push without full queue");

    // at most one request in work: no accept in the cycle after an accept
    a_one_in_work: assert property (@(posedge clk) disable iff (!rst_n)
        in_valid && in_ready |=> !in_ready)
        else $error("second request taken while one is in work");

endmodule

bind double_ended_ring_queue_top derq_checker #(.DEPTH(DEPTH)) u_derq_checker (.*);
`default_nettype wire
